[hdl/bal_pkg.sv]
// Shared types and constants for the bounded array list engine.
// No dependencies; bal_ctrl and the top module refer to it by scoped names, bal_ram does not use it.
package bal_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_POS  = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_TAIL = 3'd4,
    ACT_REM_POS  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FILL
  } state_t;

  typedef struct packed {
    action_t                   action;
    logic signed [DATA_W-1:0]  value_in;
    logic [POS_W-1:0]          position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value_out;
    status_t                   status;
    logic [POS_W-1:0]          entry_count;
  } rsp_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

endpackage

[hdl/bounded_array_list_engine.sv]
// Bounded array list engine: an ordered list of signed 32-bit values with insert
// and remove at head, tail or position. An accepted request (start high, busy low)
// returns one result beat, shown for a single cycle with done high; the receiver
// cannot stall it, so capture it on that cycle. Rejected requests (full, empty,
// bad position, unused action) answer on the next cycle. Work is bounded by the
// single-port-per-direction entry RAM, which moves one entry per cycle: an insert
// shifts the entries from the index to the tail up one place and then writes the
// value, a removal shifts the entries above the index down one place, index being
// where the entry goes in or comes out. Uses bal_pkg, bal_ram and bal_ctrl.
module bounded_array_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  bal_pkg::req_t request,
  output logic          done,
  output bal_pkg::rsp_t result
);

  bal_pkg::mem_req_t          mem_req;
  logic [bal_pkg::DATA_W-1:0] rdata;

  bal_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  bal_ram #(
    .DEPTH (bal_pkg::CAPACITY),
    .WIDTH (bal_pkg::DATA_W)
  ) u_entries (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

endmodule

[hdl/bal_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bal_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bal_ctrl.sv]
// Request decoder and shift sequencer for the bounded array list engine.
// Uses bal_pkg; drives the entry RAM through a bal_pkg::mem_req_t bundle.
module bal_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  bal_pkg::req_t              request,
  output logic                       done,
  output bal_pkg::rsp_t              result,
  output bal_pkg::mem_req_t          mem_req,
  input  logic [bal_pkg::DATA_W-1:0] rdata
);

  bal_pkg::state_t               state;
  bal_pkg::state_t               state_next;
  logic [bal_pkg::CNT_W-1:0]     count;
  logic                          up;
  logic [bal_pkg::IDX_W-1:0]     at;
  logic [bal_pkg::DATA_W-1:0]    value;
  logic [bal_pkg::IDX_W-1:0]     ptr;
  logic                          more;
  logic                          pend;
  logic [bal_pkg::IDX_W-1:0]     pend_addr;
  logic [bal_pkg::DATA_W-1:0]    rem_val;

  // Decode of the incoming request against the current count.
  logic                          accept;
  logic                          dec_ok;
  logic                          dec_up;
  logic [bal_pkg::IDX_W-1:0]     dec_at;
  bal_pkg::status_t              dec_status;
  logic                          is_full;
  logic                          is_empty;
  logic [bal_pkg::CMP_W-1:0]     pos_ext;
  logic [bal_pkg::CMP_W-1:0]     cnt_ext;
  logic [bal_pkg::IDX_W-1:0]     last_idx;
  logic                          ptr_end;
  logic [bal_pkg::DATA_W-1:0]    fin_val;

  assign accept   = start && !busy;
  assign busy     = (state != bal_pkg::ST_IDLE);
  assign is_full  = (count == bal_pkg::CNT_W'(bal_pkg::CAPACITY));
  assign is_empty = (count == '0);
  assign pos_ext  = bal_pkg::CMP_W'(request.position);
  assign cnt_ext  = bal_pkg::CMP_W'(count);
  assign last_idx = bal_pkg::IDX_W'(count - bal_pkg::CNT_W'(1));
  assign ptr_end  = up ? (ptr == at) : (ptr == last_idx);
  // The removed entry is the first one read; it may still be in flight at the end.
  assign fin_val  = (pend && (pend_addr == at)) ? rdata : rem_val;

  always_comb begin
    dec_ok     = 1'b0;
    dec_up     = 1'b1;
    dec_at     = '0;
    dec_status = bal_pkg::STS_OK;
    case (request.action)
      bal_pkg::ACT_INS_HEAD, bal_pkg::ACT_INS_TAIL, bal_pkg::ACT_INS_POS: begin
        if (is_full) begin
          dec_status = bal_pkg::STS_FULL;
        end else if (request.action == bal_pkg::ACT_INS_HEAD) begin
          dec_ok = 1'b1;
        end else if (request.action == bal_pkg::ACT_INS_TAIL) begin
          dec_ok = 1'b1;
          dec_at = bal_pkg::IDX_W'(count);
        end else if (pos_ext > cnt_ext) begin
          dec_status = bal_pkg::STS_RANGE;
        end else begin
          dec_ok = 1'b1;
          dec_at = bal_pkg::IDX_W'(pos_ext);
        end
      end
      bal_pkg::ACT_REM_HEAD, bal_pkg::ACT_REM_TAIL, bal_pkg::ACT_REM_POS: begin
        dec_up = 1'b0;
        if (is_empty) begin
          dec_status = bal_pkg::STS_EMPTY;
        end else if (request.action == bal_pkg::ACT_REM_HEAD) begin
          dec_ok = 1'b1;
        end else if (request.action == bal_pkg::ACT_REM_TAIL) begin
          dec_ok = 1'b1;
          dec_at = last_idx;
        end else if (pos_ext >= cnt_ext) begin
          dec_status = bal_pkg::STS_RANGE;
        end else begin
          dec_ok = 1'b1;
          dec_at = bal_pkg::IDX_W'(pos_ext);
        end
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      bal_pkg::ST_IDLE: begin
        if (accept && dec_ok) begin
          state_next = bal_pkg::ST_SHIFT;
        end
      end
      bal_pkg::ST_SHIFT: begin
        if (!more) begin
          state_next = up ? bal_pkg::ST_FILL : bal_pkg::ST_IDLE;
        end
      end
      bal_pkg::ST_FILL: begin
        state_next = bal_pkg::ST_IDLE;
      end
      default: begin
        state_next = bal_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory port drive. Reads walk one way while the delayed writes trail them.
  always_comb begin
    mem_req = '0;
    case (state)
      bal_pkg::ST_SHIFT: begin
        mem_req.re    = more;
        mem_req.raddr = ptr;
        mem_req.we    = pend && (up || (pend_addr != at));
        mem_req.waddr = up ? (pend_addr + bal_pkg::IDX_W'(1))
                           : (pend_addr - bal_pkg::IDX_W'(1));
        mem_req.wdata = rdata;
      end
      bal_pkg::ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = at;
        mem_req.wdata = value;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bal_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
      more  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        bal_pkg::ST_IDLE: begin
          if (accept) begin
            up    <= dec_up;
            at    <= dec_at;
            value <= request.value_in;
            ptr   <= dec_up ? last_idx : dec_at;
            more  <= dec_up ? (bal_pkg::IDX_W'(count) != dec_at) : 1'b1;
            pend  <= 1'b0;
            if (!dec_ok) begin
              done               <= 1'b1;
              result.value_out   <= '0;
              result.status      <= dec_status;
              result.entry_count <= bal_pkg::POS_W'(cnt_ext);
            end
          end
        end
        bal_pkg::ST_SHIFT: begin
          pend      <= more;
          pend_addr <= ptr;
          if (pend && (pend_addr == at) && !up) begin
            rem_val <= rdata;
          end
          if (more) begin
            if (ptr_end) begin
              more <= 1'b0;
            end else begin
              ptr <= up ? (ptr - bal_pkg::IDX_W'(1)) : (ptr + bal_pkg::IDX_W'(1));
            end
          end else if (!up) begin
            count              <= count - bal_pkg::CNT_W'(1);
            done               <= 1'b1;
            result.value_out   <= fin_val;
            result.status      <= bal_pkg::STS_OK;
            result.entry_count <= bal_pkg::POS_W'(bal_pkg::CMP_W'(count - bal_pkg::CNT_W'(1)));
          end
        end
        bal_pkg::ST_FILL: begin
          count              <= count + bal_pkg::CNT_W'(1);
          done               <= 1'b1;
          result.value_out   <= '0;
          result.status      <= bal_pkg::STS_OK;
          result.entry_count <= bal_pkg::POS_W'(bal_pkg::CMP_W'(count + bal_pkg::CNT_W'(1)));
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == bal_pkg::ST_IDLE)
    else $error("result strobe outside idle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("shift reads and writes the same entry");

  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    state == bal_pkg::ST_FILL |=> done && (count == $past(count) + bal_pkg::CNT_W'(1)))
    else $error("insert did not grow the list by one");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != bal_pkg::STS_OK)) |-> $stable(count))
    else $error("rejected request changed the count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state == bal_pkg::ST_SHIFT |-> count <= bal_pkg::CNT_W'(bal_pkg::CAPACITY))
    else $error("count beyond capacity");

endmodule
